### src/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int EARTH_RADIUS_M = 6371210;

   localparam int SQRT_STAGES = 32;
   localparam int FRONT_STAGES = 6;
   localparam int POST_STAGES = 3;
   localparam int FINAL_STAGES = 2;
   localparam int LATENCY = FRONT_STAGES + CORDIC_STAGES + POST_STAGES + SQRT_STAGES
                            + CORDIC_STAGES + FINAL_STAGES;

   localparam int ZW = 36;
   localparam int DW = 34;
   localparam int KW = 31;
   localparam int PW = 2 * KW;
   localparam int QW = 32;
   localparam int RW = 24;
   localparam int OW = 25;

   localparam int ROT_LANES = 4;
   localparam int LANE_HLAT = 0;
   localparam int LANE_HLON = 1;
   localparam int LANE_COSA = 2;
   localparam int LANE_COSB = 3;

   localparam int SQRT_LANES = 2;
   localparam int ROOT_A = 0;
   localparam int ROOT_C = 1;

   localparam int RAD_SHIFT = 28;

   localparam logic signed [DW-1:0] HALF_TURN = DW'(64'd1800000000);
   localparam logic signed [DW-1:0] FULL_TURN = DW'(64'd3600000000);
   localparam logic signed [DW-1:0] QUARTER_TURN = DW'(64'd900000000);

   localparam logic [63:0] RAD_Q60 = 64'h3243F6A8885A308D / 64'd1800000000;
   localparam logic [KW-1:0] RAD_PER_UNIT = RAD_Q60[KW-1:0];

   localparam logic signed [ZW-1:0] INV_GAIN_Q32 = ZW'(64'd2608131496);
   localparam logic [QW:0] ONE_Q32 = {1'b1, {QW{1'b0}}};
   localparam logic [RW-1:0] TWO_R = RW'(2 * EARTH_RADIUS_M);

   typedef struct packed {
      logic neg_a;
      logic neg_b;
   } cos_sign_type;

   function automatic logic signed [ZW-1:0] atan_q32(input int unsigned i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = ZW'(64'd3373259426);
         1: r = ZW'(64'd1991351318);
         2: r = ZW'(64'd1052175346);
         3: r = ZW'(64'd534100635);
         4: r = ZW'(64'd268086748);
         5: r = ZW'(64'd134174063);
         6: r = ZW'(64'd67103403);
         7: r = ZW'(64'd33553749);
         8: r = ZW'(64'd16777131);
         9: r = ZW'(64'd8388597);
         10: r = ZW'(64'd4194303);
         default: r = (i <= 32) ? ZW'(64'd1 << (32 - i)) : '0;
      endcase
      return r;
   endfunction

   function automatic logic [QW-1:0] clamp_mag(input logic signed [ZW-1:0] v);
      logic [ZW-1:0] m;
      m = v[ZW-1] ? ZW'(-v) : ZW'(v);
      return (m > ZW'({QW{1'b1}})) ? {QW{1'b1}} : m[QW-1:0];
   endfunction

   function automatic logic [QW-1:0] mul_q32(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic [2*QW-1:0] p;
      p = 64'(a) * 64'(b) + 64'(64'd1 << (QW - 1));
      return p[2*QW-1:QW];
   endfunction

endpackage

### src/great_circle_distance.sv
`timescale 1ns / 1ps
// path from accept to rsp_valid: front, rotation cordic, post, square root, vectoring cordic, final registers
// throughput: one item per cycle outside reset, set by the fully pipelined cordic and root stages
// busy is high only during reset; the receiver cannot stall, results are never held
// synchronous active-high reset clears all valid bits, payload registers are not reset

module great_circle_distance (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [30:0] req_lat_a,
   input  logic signed [31:0] req_lon_b,
   input  logic signed [30:0] req_lat_b,
   output logic rsp_valid,
   output logic [gcd_pkg::OW-1:0] rsp_distance_m
);

   localparam int L = gcd_pkg::ROT_LANES;
   localparam int N = gcd_pkg::CORDIC_STAGES;
   localparam int ZW = gcd_pkg::ZW;
   localparam int QW = gcd_pkg::QW;
   localparam int RW = gcd_pkg::RW;
   localparam int MW = RW + ZW - 1;

   logic accept;
   logic front_valid, rot_valid, sq_valid, vec_valid;
   logic signed [ZW-1:0] theta [L];
   logic signed [ZW-1:0] cos_x [L];
   logic signed [ZW-1:0] sin_y [L];
   gcd_pkg::cos_sign_type front_sign;
   gcd_pkg::cos_sign_type sign_pipe_ff [N];

   logic [gcd_pkg::POST_STAGES-1:0] pv_ff;
   logic [QW-1:0] hlat_ff, hlon_ff, cc_ff, hlat2_ff, term_ff;
   logic [QW-1:0] hlat_in, hlon_in, cc_in, term_in;
   logic diff1_ff, diff2_ff;
   logic [QW:0] a_ff, ac_ff, a_in, ac_in;
   logic [QW:0] sq_value [gcd_pkg::SQRT_LANES];
   logic [QW:0] sq_root [gcd_pkg::SQRT_LANES];
   logic signed [ZW-1:0] angle;

   logic f1_valid_ff, rsp_valid_ff;
   logic [MW-1:0] prod_ff, prod_in;
   logic [gcd_pkg::OW-1:0] dist_ff, dist_in;

   assign busy = reset;
   assign accept = start && !busy;

   gcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .lon_a     (req_lon_a),
      .lat_a     (req_lat_a),
      .lon_b     (req_lon_b),
      .lat_b     (req_lat_b),
      .out_valid (front_valid),
      .theta     (theta),
      .cos_sign  (front_sign)
   );

   gcd_cordic_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .theta     (theta),
      .out_valid (rot_valid),
      .cos_out   (cos_x),
      .sin_out   (sin_y)
   );

   always_ff @(posedge clock) begin
      sign_pipe_ff[0] <= front_sign;
      for (int s = 1; s < N; s++) begin
         sign_pipe_ff[s] <= sign_pipe_ff[s-1];
      end
   end

   always_comb begin
      logic [QW-1:0] mlat, mlon, ca, cb;
      mlat = gcd_pkg::clamp_mag(sin_y[gcd_pkg::LANE_HLAT]);
      mlon = gcd_pkg::clamp_mag(sin_y[gcd_pkg::LANE_HLON]);
      ca = cos_x[gcd_pkg::LANE_COSA][ZW-1] ? '0 : gcd_pkg::clamp_mag(cos_x[gcd_pkg::LANE_COSA]);
      cb = cos_x[gcd_pkg::LANE_COSB][ZW-1] ? '0 : gcd_pkg::clamp_mag(cos_x[gcd_pkg::LANE_COSB]);
      hlat_in = gcd_pkg::mul_q32(mlat, mlat);
      hlon_in = gcd_pkg::mul_q32(mlon, mlon);
      cc_in = gcd_pkg::mul_q32(ca, cb);
      term_in = gcd_pkg::mul_q32(cc_ff, hlon_ff);
   end

   always_comb begin
      logic signed [QW+2:0] sum;
      if (diff2_ff) begin
         sum = (QW + 3)'(hlat2_ff) - (QW + 3)'(term_ff);
      end else begin
         sum = (QW + 3)'(hlat2_ff) + (QW + 3)'(term_ff);
      end
      if (sum[QW+2]) begin
         a_in = '0;
      end else if (sum > (QW + 3)'(gcd_pkg::ONE_Q32)) begin
         a_in = gcd_pkg::ONE_Q32;
      end else begin
         a_in = sum[QW:0];
      end
      ac_in = gcd_pkg::ONE_Q32 - a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[gcd_pkg::POST_STAGES-2:0], rot_valid};
      end
   end

   always_ff @(posedge clock) begin
      hlat_ff <= hlat_in;
      hlon_ff <= hlon_in;
      cc_ff <= cc_in;
      diff1_ff <= sign_pipe_ff[N-1].neg_a ^ sign_pipe_ff[N-1].neg_b;
      hlat2_ff <= hlat_ff;
      term_ff <= term_in;
      diff2_ff <= diff1_ff;
      a_ff <= a_in;
      ac_ff <= ac_in;
   end

   always_comb begin
      sq_value[gcd_pkg::ROOT_A] = a_ff;
      sq_value[gcd_pkg::ROOT_C] = ac_ff;
   end

   gcd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff[gcd_pkg::POST_STAGES-1]),
      .value     (sq_value),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   gcd_cordic_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .x_start   (sq_root[gcd_pkg::ROOT_C]),
      .y_start   (sq_root[gcd_pkg::ROOT_A]),
      .out_valid (vec_valid),
      .angle     (angle)
   );

   always_comb begin
      logic [ZW-2:0] ang;
      logic [MW:0] sum;
      ang = angle[ZW-1] ? '0 : angle[ZW-2:0];
      prod_in = MW'(gcd_pkg::TWO_R) * MW'(ang);
      sum = (MW + 1)'(prod_ff) + (MW + 1)'(64'd1 << (QW - 1));
      dist_in = sum[QW+gcd_pkg::OW-1:QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= vec_valid;
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dist_ff <= dist_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance_m = dist_ff;

`ifndef SYNTHESIS
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, gcd_pkg::LATENCY))
      else $error("result without matching accepted item");

   a_roots_in_range: assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> (sq_root[gcd_pkg::ROOT_A] <= gcd_pkg::ONE_Q32 &&
                    sq_root[gcd_pkg::ROOT_C] <= gcd_pkg::ONE_Q32))
      else $error("square root above one");
`endif

endmodule

### src/gcd_front.sv
`timescale 1ns / 1ps

module gcd_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [31:0] lon_a,
   input  logic signed [30:0] lat_a,
   input  logic signed [31:0] lon_b,
   input  logic signed [30:0] lat_b,
   output logic out_valid,
   output logic signed [gcd_pkg::ZW-1:0] theta [gcd_pkg::ROT_LANES],
   output gcd_pkg::cos_sign_type cos_sign
);

   localparam int L = gcd_pkg::ROT_LANES;
   localparam int DW = gcd_pkg::DW;
   localparam int KW = gcd_pkg::KW;
   localparam int PW = gcd_pkg::PW;
   localparam int ZW = gcd_pkg::ZW;

   logic [gcd_pkg::FRONT_STAGES-1:0] v_ff, v_in;

   logic signed [31:0] lon_a_ff, lon_b_ff;
   logic signed [30:0] lat_a_ff, lat_b_ff;

   logic signed [DW-1:0] diff_ff [L];
   logic signed [DW-1:0] diff_in [L];
   logic signed [DW-1:0] val_ff [L];
   logic signed [DW-1:0] val_in [L];
   logic [KW-1:0] mag_ff [L];
   logic [KW-1:0] mag_in [L];
   logic [L-1:0] sgn_ff, sgn_in, sgn2_ff;
   logic [PW-1:0] prod_ff [L];
   logic [PW-1:0] prod_in [L];
   logic signed [ZW-1:0] theta_ff [L];
   logic signed [ZW-1:0] theta_in [L];
   gcd_pkg::cos_sign_type s3_ff, s3_in, s4_ff, s5_ff, s6_ff;

   always_comb begin
      v_in = {v_ff[gcd_pkg::FRONT_STAGES-2:0], in_valid};
   end

   always_comb begin
      diff_in[gcd_pkg::LANE_HLAT] = DW'(lat_b_ff) - DW'(lat_a_ff);
      diff_in[gcd_pkg::LANE_HLON] = DW'(lon_b_ff) - DW'(lon_a_ff);
      diff_in[gcd_pkg::LANE_COSA] = DW'(lat_a_ff);
      diff_in[gcd_pkg::LANE_COSB] = DW'(lat_b_ff);
   end

   always_comb begin
      logic [L-1:0] neg;
      neg = '0;
      for (int l = 0; l < L; l++) begin
         if (l == gcd_pkg::LANE_HLAT || l == gcd_pkg::LANE_HLON) begin
            if (diff_ff[l] > gcd_pkg::HALF_TURN) begin
               val_in[l] = diff_ff[l] - gcd_pkg::FULL_TURN;
            end else if (diff_ff[l] < -gcd_pkg::HALF_TURN) begin
               val_in[l] = diff_ff[l] + gcd_pkg::FULL_TURN;
            end else begin
               val_in[l] = diff_ff[l];
            end
         end else begin
            if (diff_ff[l] > gcd_pkg::QUARTER_TURN) begin
               val_in[l] = gcd_pkg::HALF_TURN - diff_ff[l];
               neg[l] = 1'b1;
            end else if (diff_ff[l] < -gcd_pkg::QUARTER_TURN) begin
               val_in[l] = -gcd_pkg::HALF_TURN - diff_ff[l];
               neg[l] = 1'b1;
            end else begin
               val_in[l] = diff_ff[l];
            end
         end
      end
      s3_in.neg_a = neg[gcd_pkg::LANE_COSA];
      s3_in.neg_b = neg[gcd_pkg::LANE_COSB];
   end

   always_comb begin
      for (int l = 0; l < L; l++) begin
         sgn_in[l] = val_ff[l][DW-1];
         mag_in[l] = val_ff[l][DW-1] ? KW'(-val_ff[l]) : KW'(val_ff[l]);
         prod_in[l] = PW'(mag_ff[l]) * PW'(gcd_pkg::RAD_PER_UNIT);
      end
   end

   always_comb begin
      logic [PW:0] sum;
      logic [PW:0] r;
      int sh;
      sum = '0;
      r = '0;
      sh = 0;
      for (int l = 0; l < L; l++) begin
         sh = (l == gcd_pkg::LANE_HLAT || l == gcd_pkg::LANE_HLON) ?
              gcd_pkg::RAD_SHIFT + 1 : gcd_pkg::RAD_SHIFT;
         sum = (PW + 1)'(prod_ff[l]) + (PW + 1)'(65'd1 << (sh - 1));
         r = sum >> sh;
         theta_in[l] = sgn2_ff[l] ? -ZW'(r) : ZW'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      lon_a_ff <= lon_a;
      lat_a_ff <= lat_a;
      lon_b_ff <= lon_b;
      lat_b_ff <= lat_b;
      diff_ff <= diff_in;
      val_ff <= val_in;
      mag_ff <= mag_in;
      sgn_ff <= sgn_in;
      sgn2_ff <= sgn_ff;
      prod_ff <= prod_in;
      theta_ff <= theta_in;
      s3_ff <= s3_in;
      s4_ff <= s3_ff;
      s5_ff <= s4_ff;
      s6_ff <= s5_ff;
   end

   assign out_valid = v_ff[gcd_pkg::FRONT_STAGES-1];
   assign theta = theta_ff;
   assign cos_sign = s6_ff;

endmodule

### src/gcd_cordic_rot.sv
`timescale 1ns / 1ps

module gcd_cordic_rot (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [gcd_pkg::ZW-1:0] theta [gcd_pkg::ROT_LANES],
   output logic out_valid,
   output logic signed [gcd_pkg::ZW-1:0] cos_out [gcd_pkg::ROT_LANES],
   output logic signed [gcd_pkg::ZW-1:0] sin_out [gcd_pkg::ROT_LANES]
);

   localparam int L = gcd_pkg::ROT_LANES;
   localparam int N = gcd_pkg::CORDIC_STAGES;
   localparam int ZW = gcd_pkg::ZW;

   logic [N-1:0] v_ff;
   logic signed [ZW-1:0] x_ff [L][N];
   logic signed [ZW-1:0] y_ff [L][N];
   logic signed [ZW-1:0] z_ff [L][N];
   logic signed [ZW-1:0] x_in [L][N];
   logic signed [ZW-1:0] y_in [L][N];
   logic signed [ZW-1:0] z_in [L][N];

   always_comb begin
      logic signed [ZW-1:0] xp, yp, zp, xs, ys, at;
      for (int l = 0; l < L; l++) begin
         for (int s = 0; s < N; s++) begin
            if (s == 0) begin
               xp = gcd_pkg::INV_GAIN_Q32;
               yp = '0;
               zp = theta[l];
            end else begin
               xp = x_ff[l][s-1];
               yp = y_ff[l][s-1];
               zp = z_ff[l][s-1];
            end
            xs = xp >>> s;
            ys = yp >>> s;
            at = gcd_pkg::atan_q32(s);
            if (!zp[ZW-1]) begin
               x_in[l][s] = xp - ys;
               y_in[l][s] = yp + xs;
               z_in[l][s] = zp - at;
            end else begin
               x_in[l][s] = xp + ys;
               y_in[l][s] = yp - xs;
               z_in[l][s] = zp + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_valid = v_ff[N-1];

   always_comb begin
      for (int l = 0; l < L; l++) begin
         cos_out[l] = x_ff[l][N-1];
         sin_out[l] = y_ff[l][N-1];
      end
   end

endmodule

### src/gcd_sqrt.sv
`timescale 1ns / 1ps

module gcd_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [gcd_pkg::QW:0] value [gcd_pkg::SQRT_LANES],
   output logic out_valid,
   output logic [gcd_pkg::QW:0] root [gcd_pkg::SQRT_LANES]
);

   localparam int L = gcd_pkg::SQRT_LANES;
   localparam int N = gcd_pkg::SQRT_STAGES;
   localparam int QW = gcd_pkg::QW;

   logic [N-1:0] v_ff;
   logic [2*QW-1:0] n_ff [L][N];
   logic [2*QW-1:0] n_in [L][N];
   logic [2*QW-1:0] r_ff [L][N];
   logic [2*QW-1:0] r_in [L][N];
   logic [N-1:0] one_ff [L];
   logic [N-1:0] one_in [L];

   always_comb begin
      logic [2*QW-1:0] np, rp, t, bitv;
      logic op;
      for (int l = 0; l < L; l++) begin
         for (int s = 0; s < N; s++) begin
            if (s == 0) begin
               np = {value[l][QW-1:0], {QW{1'b0}}};
               rp = '0;
               op = value[l][QW];
            end else begin
               np = n_ff[l][s-1];
               rp = r_ff[l][s-1];
               op = one_ff[l][s-1];
            end
            bitv = 64'd1 << (2 * QW - 2 - 2 * s);
            t = rp + bitv;
            one_in[l][s] = op;
            if (np >= t) begin
               n_in[l][s] = np - t;
               r_in[l][s] = (rp >> 1) + bitv;
            end else begin
               n_in[l][s] = np;
               r_in[l][s] = rp >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
      one_ff <= one_in;
   end

   assign out_valid = v_ff[N-1];

   always_comb begin
      for (int l = 0; l < L; l++) begin
         root[l] = one_ff[l][N-1] ? gcd_pkg::ONE_Q32 : {1'b0, r_ff[l][N-1][QW-1:0]};
      end
   end

endmodule

### src/gcd_cordic_vec.sv
`timescale 1ns / 1ps

module gcd_cordic_vec (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [gcd_pkg::QW:0] x_start,
   input  logic [gcd_pkg::QW:0] y_start,
   output logic out_valid,
   output logic signed [gcd_pkg::ZW-1:0] angle
);

   localparam int N = gcd_pkg::CORDIC_STAGES;
   localparam int ZW = gcd_pkg::ZW;

   logic [N-1:0] v_ff;
   logic signed [ZW-1:0] x_ff [N];
   logic signed [ZW-1:0] y_ff [N];
   logic signed [ZW-1:0] z_ff [N];
   logic signed [ZW-1:0] x_in [N];
   logic signed [ZW-1:0] y_in [N];
   logic signed [ZW-1:0] z_in [N];

   always_comb begin
      logic signed [ZW-1:0] xp, yp, zp, xs, ys, at;
      for (int s = 0; s < N; s++) begin
         if (s == 0) begin
            xp = ZW'(x_start);
            yp = ZW'(y_start);
            zp = '0;
         end else begin
            xp = x_ff[s-1];
            yp = y_ff[s-1];
            zp = z_ff[s-1];
         end
         xs = xp >>> s;
         ys = yp >>> s;
         at = gcd_pkg::atan_q32(s);
         if (yp > 0) begin
            x_in[s] = xp + ys;
            y_in[s] = yp - xs;
            z_in[s] = zp + at;
         end else begin
            x_in[s] = xp - ys;
            y_in[s] = yp + xs;
            z_in[s] = zp - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_valid = v_ff[N-1];
   assign angle = z_ff[N-1];

endmodule
